// ----- hdl/lrs_pkg.sv -----
// Shared constants for the LED row-scan triple-buffer controller.
// Command codes, sequencer state codes, driver mode codes, config register indices, reset values and geometry.
// No dependencies.
package lrs_pkg;

  localparam int NUM_ROWS = 16;
  localparam int NUM_COLS = 16;
  localparam int ROW_W    = $clog2(NUM_ROWS);
  localparam int HALF     = NUM_ROWS / 2;
  localparam int ADDR_W   = 16;
  localparam int CNT_W    = 20;

  localparam logic [3:0] CMD_TICK      = 4'd0;
  localparam logic [3:0] CMD_LATCH     = 4'd1;
  localparam logic [3:0] CMD_ROW_UPD   = 4'd2;
  localparam logic [3:0] CMD_DMA_DONE  = 4'd3;
  localparam logic [3:0] CMD_DMA_ABORT = 4'd4;
  localparam logic [3:0] CMD_DMA_RESET = 4'd5;
  localparam logic [3:0] CMD_SWAP_REQ  = 4'd6;
  localparam logic [3:0] CMD_DETECT    = 4'd7;
  localparam logic [3:0] CMD_PIXEL     = 4'd8;

  localparam logic [3:0] ST_ENABLE      = 4'd0;
  localparam logic [3:0] ST_ENABLE_WAIT = 4'd1;
  localparam logic [3:0] ST_IDLE        = 4'd2;
  localparam logic [3:0] ST_DETECT      = 4'd3;
  localparam logic [3:0] ST_DETECT_MODE = 4'd4;
  localparam logic [3:0] ST_DETECT_WAIT = 4'd5;
  localparam logic [3:0] ST_ADVANCE     = 4'd6;
  localparam logic [3:0] ST_SETTLE      = 4'd7;
  localparam logic [3:0] ST_ERROR       = 4'd8;

  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_ENABLED = 2'd1;
  localparam logic [1:0] MODE_DETECT  = 2'd2;

  localparam logic [1:0] REG_INTERLACED = 2'd0;
  localparam logic [1:0] REG_AUTO_SWAP  = 2'd1;
  localparam logic [1:0] REG_SETTLE     = 2'd2;
  localparam logic [1:0] REG_ERROR      = 2'd3;

  localparam logic [15:0] SETTLE_RESET = 16'd10;
  localparam logic [19:0] ERROR_RESET  = 20'd1000000;

endpackage

// ----- hdl/led_row_scan_triple_buffer_ctrl.sv -----
// An accepted request's result is in the output register in the cycle after acceptance.
// Throughput: one request per cycle while the output is not stalled; the output register is refilled as it is taken.
// All state updates for a request are combinational logic feeding the state registers.
// Reset (rst, synchronous): sequencer asks for enabled mode first, rows cleared,
// buffers draw 0 / sync 1 / receive 2, registers 0, 0, 10, 1000000.
module led_row_scan_triple_buffer_ctrl (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  command,
  input  logic [7:0]  pixel_x,
  input  logic [7:0]  pixel_y,
  input  logic [1:0]  driver_mode,
  input  logic        open_fault,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  mode_request,
  output logic        row_on,
  output logic [3:0]  active_row,
  output logic [1:0]  buffer_select,
  output logic [7:0]  element_address,
  output logic        accepted,
  output logic        busy_res,
  output logic        dma_fault,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  logic                        interlaced;
  logic                        auto_swap;
  logic [15:0]                 settle_ticks;
  logic [19:0]                 error_ticks;

  logic [3:0]                  seq_state, seq_state_next;
  logic [lrs_pkg::CNT_W-1:0]   countdown, countdown_next;
  logic [lrs_pkg::ROW_W-1:0]   row_index, row_index_next;
  logic [lrs_pkg::ROW_W-1:0]   next_row, next_row_next;
  logic                        row_driven, row_driven_next;
  logic [1:0]                  draw_buf, draw_buf_next;
  logic [1:0]                  sync_buf, sync_buf_next;
  logic [1:0]                  recv_buf, recv_buf_next;
  logic                        swap_pending, swap_pending_next;
  logic                        dma_failed, dma_failed_next;

  logic                        in_fire;
  logic [1:0]                  req;
  logic [lrs_pkg::ADDR_W-1:0]  addr;
  logic                        acc;
  logic                        use_recv;
  logic                        at_last_row;
  logic [3:0]                  last_done_state;
  logic [lrs_pkg::ROW_W-1:0]   step_after;
  logic [lrs_pkg::ROW_W-1:0]   scan_pos;
  logic [lrs_pkg::ROW_W:0]     phys_row;
  logic [7:0]                  px_c, py_c;

  assign in_stall = out_valid & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  assign at_last_row     = row_index >= lrs_pkg::ROW_W'(lrs_pkg::NUM_ROWS - 1);
  assign last_done_state = at_last_row ? lrs_pkg::ST_ENABLE : lrs_pkg::ST_ADVANCE;
  assign step_after      = (next_row >= lrs_pkg::ROW_W'(lrs_pkg::NUM_ROWS - 1)) ?
                           '0 : next_row + 1'b1;
  assign scan_pos        = row_driven ? next_row : '0;
  assign phys_row        = (scan_pos < lrs_pkg::ROW_W'(lrs_pkg::HALF)) ?
                           {scan_pos, 1'b1} :
                           {scan_pos - lrs_pkg::ROW_W'(lrs_pkg::HALF), 1'b0};
  assign px_c = (pixel_x >= 8'(lrs_pkg::NUM_COLS)) ? 8'(lrs_pkg::NUM_COLS - 1) : pixel_x;
  assign py_c = (pixel_y >= 8'(lrs_pkg::NUM_ROWS)) ? 8'(lrs_pkg::NUM_ROWS - 1) : pixel_y;

  always_comb begin
    seq_state_next    = seq_state;
    countdown_next    = countdown;
    row_index_next    = row_index;
    next_row_next     = next_row;
    row_driven_next   = row_driven;
    draw_buf_next     = draw_buf;
    sync_buf_next     = sync_buf;
    recv_buf_next     = recv_buf;
    swap_pending_next = swap_pending;
    dma_failed_next   = dma_failed;
    req               = lrs_pkg::MODE_NONE;
    addr              = '0;
    acc               = 1'b0;
    use_recv          = 1'b0;
    case (command)
      lrs_pkg::CMD_TICK: begin
        case (seq_state)
          lrs_pkg::ST_ENABLE_WAIT: begin
            if (driver_mode == lrs_pkg::MODE_ENABLED) begin
              row_driven_next = 1'b0;
              row_index_next  = '0;
              next_row_next   = '0;
              seq_state_next  = lrs_pkg::ST_IDLE;
            end
          end
          lrs_pkg::ST_IDLE: begin
            seq_state_next = lrs_pkg::ST_IDLE;
          end
          lrs_pkg::ST_DETECT, lrs_pkg::ST_DETECT_MODE: begin
            req            = lrs_pkg::MODE_DETECT;
            seq_state_next = lrs_pkg::ST_DETECT_WAIT;
          end
          lrs_pkg::ST_DETECT_WAIT: begin
            if (driver_mode == lrs_pkg::MODE_DETECT) begin
              row_driven_next = 1'b0;
              row_index_next  = '0;
              next_row_next   = '0;
              seq_state_next  = lrs_pkg::ST_ADVANCE;
            end
          end
          lrs_pkg::ST_ADVANCE: begin
            row_driven_next = 1'b1;
            row_index_next  = next_row;
            next_row_next   = step_after;
            countdown_next  = lrs_pkg::CNT_W'(settle_ticks);
            seq_state_next  = lrs_pkg::ST_SETTLE;
          end
          lrs_pkg::ST_SETTLE: begin
            if (countdown != '0) begin
              countdown_next = countdown - 1'b1;
            end else if (open_fault) begin
              countdown_next = error_ticks;
              seq_state_next = lrs_pkg::ST_ERROR;
            end else begin
              seq_state_next = last_done_state;
            end
          end
          lrs_pkg::ST_ERROR: begin
            if (countdown != '0) begin
              countdown_next = countdown - 1'b1;
            end else begin
              seq_state_next = last_done_state;
            end
          end
          default: begin
            req            = lrs_pkg::MODE_ENABLED;
            seq_state_next = lrs_pkg::ST_ENABLE_WAIT;
          end
        endcase
      end
      lrs_pkg::CMD_LATCH: begin
        if (at_last_row && swap_pending) begin
          draw_buf_next     = sync_buf;
          sync_buf_next     = draw_buf;
          swap_pending_next = 1'b0;
        end
        row_driven_next = 1'b1;
        row_index_next  = next_row;
        next_row_next   = step_after;
      end
      lrs_pkg::CMD_ROW_UPD: begin
        if (interlaced) begin
          addr = lrs_pkg::ADDR_W'(phys_row) * lrs_pkg::ADDR_W'(lrs_pkg::NUM_COLS);
        end else begin
          addr = lrs_pkg::ADDR_W'(scan_pos) * lrs_pkg::ADDR_W'(lrs_pkg::NUM_COLS);
        end
      end
      lrs_pkg::CMD_DMA_DONE: begin
        if (!dma_failed) begin
          sync_buf_next = recv_buf;
          recv_buf_next = sync_buf;
          if (auto_swap) begin
            swap_pending_next = 1'b1;
          end
        end
        use_recv = 1'b1;
      end
      lrs_pkg::CMD_DMA_ABORT: begin
        dma_failed_next = 1'b1;
        use_recv        = 1'b1;
      end
      lrs_pkg::CMD_DMA_RESET: begin
        dma_failed_next = 1'b0;
        use_recv        = 1'b1;
      end
      lrs_pkg::CMD_SWAP_REQ: begin
        if (!swap_pending) begin
          swap_pending_next = 1'b1;
          acc               = 1'b1;
        end
      end
      lrs_pkg::CMD_DETECT: begin
        if (seq_state == lrs_pkg::ST_IDLE) begin
          seq_state_next = lrs_pkg::ST_DETECT;
          acc            = 1'b1;
        end
      end
      lrs_pkg::CMD_PIXEL: begin
        addr = lrs_pkg::ADDR_W'(px_c) +
               lrs_pkg::ADDR_W'(py_c) * lrs_pkg::ADDR_W'(lrs_pkg::NUM_COLS);
      end
      default: begin
        use_recv = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interlaced   <= 1'b0;
      auto_swap    <= 1'b0;
      settle_ticks <= lrs_pkg::SETTLE_RESET;
      error_ticks  <= lrs_pkg::ERROR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lrs_pkg::REG_INTERLACED: interlaced   <= cfg_data[0];
        lrs_pkg::REG_AUTO_SWAP:  auto_swap    <= cfg_data[0];
        lrs_pkg::REG_SETTLE:     settle_ticks <= cfg_data[15:0];
        lrs_pkg::REG_ERROR:      error_ticks  <= cfg_data;
        default:                 interlaced   <= interlaced;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state    <= lrs_pkg::ST_ENABLE;
      countdown    <= '0;
      row_index    <= '0;
      next_row     <= '0;
      row_driven   <= 1'b0;
      draw_buf     <= 2'd0;
      sync_buf     <= 2'd1;
      recv_buf     <= 2'd2;
      swap_pending <= 1'b0;
      dma_failed   <= 1'b0;
    end else if (in_fire) begin
      seq_state    <= seq_state_next;
      countdown    <= countdown_next;
      row_index    <= row_index_next;
      next_row     <= next_row_next;
      row_driven   <= row_driven_next;
      draw_buf     <= draw_buf_next;
      sync_buf     <= sync_buf_next;
      recv_buf     <= recv_buf_next;
      swap_pending <= swap_pending_next;
      dma_failed   <= dma_failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_request    <= req;
      row_on          <= row_driven_next;
      active_row      <= 4'(row_index_next);
      buffer_select   <= use_recv ? recv_buf_next : draw_buf_next;
      element_address <= addr[7:0];
      accepted        <= acc;
      busy_res        <= seq_state_next != lrs_pkg::ST_IDLE;
      dma_fault       <= dma_failed_next;
    end
  end

  a_bufs_distinct: assert property (@(posedge clk) disable iff (rst)
    draw_buf != sync_buf && sync_buf != recv_buf && draw_buf != recv_buf)
    else $error("frame buffer roles collide");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    row_index <= lrs_pkg::ROW_W'(lrs_pkg::NUM_ROWS - 1) &&
    next_row <= lrs_pkg::ROW_W'(lrs_pkg::NUM_ROWS - 1))
    else $error("row position out of range");

  a_countdown_in_wait: assert property (@(posedge clk) disable iff (rst)
    countdown != '0 |-> seq_state == lrs_pkg::ST_SETTLE || seq_state == lrs_pkg::ST_ERROR)
    else $error("countdown running outside a wait");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(seq_state) && $stable(row_index) && $stable(draw_buf))
    else $error("state changed while stalled");

endmodule
